FILE: src/itoa_pkg.sv
package itoa_pkg;

    // Field widths of the beats
    localparam int DATA_WIDTH    = 32;
    localparam int BASE_IN_W     = 8;
    localparam int MIN_DIG_W     = 8;
    localparam int CHAR_W        = 7;

    // Pad limit range and default
    localparam int PAD_LIMIT_DEF = 32;
    localparam int PAD_LIMIT_MAX = 61;

    // Digit storage: base 2 of the largest magnitude needs DATA_WIDTH digits
    localparam int DIG_MAX   = DATA_WIDTH;
    localparam int DIG_IDX_W = $clog2(DIG_MAX);
    localparam int CNT_W     = $clog2(((DIG_MAX > PAD_LIMIT_MAX) ? DIG_MAX : PAD_LIMIT_MAX) + 1);

    // Radix handling
    localparam int BASE_W    = 5;
    localparam int STEP_BITS = 8;
    localparam int DIV_STEPS = DATA_WIDTH / STEP_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [BASE_IN_W-1:0] BASE_MIN = 8'd2;
    localparam logic [BASE_IN_W-1:0] BASE_MAX = 8'd16;
    localparam logic [BASE_IN_W-1:0] BASE_BIN = 8'd2;
    localparam logic [BASE_IN_W-1:0] BASE_QUA = 8'd4;
    localparam logic [BASE_IN_W-1:0] BASE_OCT = 8'd8;
    localparam logic [BASE_IN_W-1:0] BASE_DEC = 8'd10;
    localparam logic [BASE_IN_W-1:0] BASE_HEX = 8'd16;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_B     = 7'h62;
    localparam logic [CHAR_W-1:0] CH_O     = 7'h6F;
    localparam logic [CHAR_W-1:0] CH_D     = 7'h64;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h37;  // 'A' minus ten

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] number;
        logic [BASE_IN_W-1:0]         base;
        logic                         with_prefix;
        logic [MIN_DIG_W-1:0]         min_digits;
    } itoa_num_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last;
    } itoa_txt_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [DATA_WIDTH-1:0] mag;
        logic                  negative;
        logic                  has_prefix;
        logic [CHAR_W-1:0]     prefix_ch;
        logic [BASE_W-1:0]     base;
        logic [CNT_W-1:0]      target;
    } itoa_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_PRE0,
        ST_PRE1,
        ST_PAD,
        ST_DIGIT
    } itoa_state_t;

    // Upper-case digit character for a value 0..15
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-4){1'b0}}, d};
        if (d < 4'd10)
            return CH_ZERO + ext;
        else
            return CH_ALPHA + ext;
    endfunction

endpackage

FILE: src/integer_to_ascii_radix_formatter.sv
// Integer to ASCII formatter for radix 2 to 16.
// Input channel num_*: one beat carries a signed number, a base, a prefix
// flag and a minimum digit count. Output channel txt_*: one beat per ASCII
// character, most significant first ('-', "0b/0o/0d/0x", zero padding,
// upper-case digits); last marks the final character of a number.
// A beat with a base outside 2..16 is accepted and produces nothing.
// Job flow: a two-entry job queue takes input beats while the back end works.
// The back end pops a job, then builds its digits: by mask and shift for
// bases 2, 4, 8 and 16, and for other bases with a radix divider retiring
// 8 quotient bits a cycle. Characters then leave at one per cycle while the
// receiver is ready. When the receiver stalls, the registered output holds
// its beat, the back end waits, and the queue fills before num_ready drops.
// Reset clears the queue, the sequencer and the output valid; no beat is
// pending afterwards.
module integer_to_ascii_radix_formatter #(
    parameter int PAD_LIMIT = itoa_pkg::PAD_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_ready,
    input  itoa_pkg::itoa_num_t num_data,
    output logic                txt_valid,
    input  logic                txt_ready,
    output itoa_pkg::itoa_txt_t txt_data
);
    import itoa_pkg::*;

    logic      push;
    logic      full;
    logic      pop;
    logic      empty;
    itoa_job_t push_job;
    itoa_job_t pop_job;

    itoa_front #(
        .PAD_LIMIT (PAD_LIMIT)
    ) u_front (
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num_data  (num_data),
        .push      (push),
        .push_job  (push_job),
        .full      (full)
    );

    itoa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .pop_job   (pop_job),
        .txt_valid (txt_valid),
        .txt_ready (txt_ready),
        .txt_data  (txt_data)
    );

endmodule

FILE: src/itoa_queue.sv
module itoa_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  itoa_pkg::itoa_job_t push_job,
    output logic                full,
    input  logic                pop,
    output itoa_pkg::itoa_job_t pop_job,
    output logic                empty
);
    import itoa_pkg::*;

    itoa_job_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: src/itoa_front.sv
module itoa_front #(
    parameter int PAD_LIMIT = itoa_pkg::PAD_LIMIT_DEF
) (
    input  logic                num_valid,
    output logic                num_ready,
    input  itoa_pkg::itoa_num_t num_data,
    output logic                push,
    output itoa_pkg::itoa_job_t push_job,
    input  logic                full
);
    import itoa_pkg::*;

    logic [DATA_WIDTH-1:0] raw;
    logic                  neg;
    logic                  base_ok;
    logic                  pre_ok;
    logic [CHAR_W-1:0]     pre_ch;

    // Accept whenever the queue has room; drop beats with a bad base
    assign num_ready = !full;
    assign push      = num_valid && !full && base_ok;

    assign raw     = num_data.number;
    assign neg     = raw[DATA_WIDTH-1];
    assign base_ok = (num_data.base >= BASE_MIN) && (num_data.base <= BASE_MAX);

    // Decode the prefix letter
    always_comb
    begin
        pre_ok = 1'b1;
        pre_ch = CH_ZERO;
        unique case (num_data.base)
            BASE_BIN: pre_ch = CH_B;
            BASE_OCT: pre_ch = CH_O;
            BASE_DEC: pre_ch = CH_D;
            BASE_HEX: pre_ch = CH_X;
            default:  pre_ok = 1'b0;
        endcase
    end

    // Build the job: magnitude, sign, prefix and saturated pad target
    always_comb
    begin
        push_job.mag        = neg ? (~raw + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : raw;
        push_job.negative   = neg;
        push_job.has_prefix = num_data.with_prefix && pre_ok;
        push_job.prefix_ch  = pre_ch;
        push_job.base       = num_data.base[BASE_W-1:0];
        if (num_data.min_digits > MIN_DIG_W'(PAD_LIMIT))
            push_job.target = CNT_W'(PAD_LIMIT);
        else
            push_job.target = num_data.min_digits[CNT_W-1:0];
    end

endmodule

FILE: src/itoa_back.sv
module itoa_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    output logic                pop,
    input  itoa_pkg::itoa_job_t pop_job,
    output logic                txt_valid,
    input  logic                txt_ready,
    output itoa_pkg::itoa_txt_t txt_data
);
    import itoa_pkg::*;

    itoa_state_t           state_reg, state_next;
    itoa_job_t             job_reg;
    logic [DATA_WIDTH-1:0] work_reg;
    logic [DATA_WIDTH-1:0] quot_reg;
    logic [3:0]            rem_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [3:0]            dig_reg [DIG_MAX];
    logic [CNT_W-1:0]      ndig_reg;
    logic [CNT_W-1:0]      pad_reg;
    logic [DIG_IDX_W-1:0]  idx_reg;
    logic                  out_valid_reg;
    itoa_txt_t             out_reg;

    logic [DATA_WIDTH-1:0] div_work;
    logic [DATA_WIDTH-1:0] div_quot;
    logic [3:0]            div_rem;
    logic                  pow2;
    logic [2:0]            shamt;
    logic [3:0]            dmask;
    logic                  digit_done;
    logic [3:0]            digit_val;
    logic [DATA_WIDTH-1:0] rest;
    logic                  div_finish;
    logic [CNT_W-1:0]      ndig_next;
    logic [CNT_W-1:0]      pad_calc;
    logic                  emit;
    logic [CHAR_W-1:0]     emit_ch;
    logic                  emit_last;
    logic                  load;

    // Eight restoring division steps per cycle on the running dividend
    always_comb
    begin
        logic [4:0]            r;
        logic [DATA_WIDTH-1:0] w;
        logic [DATA_WIDTH-1:0] q;
        r = {1'b0, rem_reg};
        w = work_reg;
        q = quot_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            r = {r[3:0], w[DATA_WIDTH-1]};
            w = {w[DATA_WIDTH-2:0], 1'b0};
            q = {q[DATA_WIDTH-2:0], 1'b0};
            if (r >= job_reg.base)
            begin
                r    = r - job_reg.base;
                q[0] = 1'b1;
            end
        end
        div_work = w;
        div_quot = q;
        div_rem  = r[3:0];
    end

    // Power-of-two bases take a digit by mask and shift
    always_comb
    begin
        pow2  = 1'b1;
        shamt = 3'd1;
        dmask = 4'h1;
        unique case (job_reg.base)
            BASE_W'(BASE_BIN): begin shamt = 3'd1; dmask = 4'h1; end
            BASE_W'(BASE_QUA): begin shamt = 3'd2; dmask = 4'h3; end
            BASE_W'(BASE_OCT): begin shamt = 3'd3; dmask = 4'h7; end
            BASE_W'(BASE_HEX): begin shamt = 3'd4; dmask = 4'hF; end
            default:           pow2 = 1'b0;
        endcase
    end

    // Pick the digit that completes this cycle
    always_comb
    begin
        if (pow2)
        begin
            digit_done = 1'b1;
            digit_val  = work_reg[3:0] & dmask;
            rest       = work_reg >> shamt;
        end
        else
        begin
            digit_done = (step_reg == STEP_W'(DIV_STEPS - 1));
            digit_val  = div_rem;
            rest       = div_quot;
        end
        ndig_next  = ndig_reg + 1'b1;
        div_finish = digit_done && ((rest == '0) || (ndig_reg == CNT_W'(DIG_MAX - 1)));
        pad_calc   = (job_reg.target > ndig_next) ? (job_reg.target - ndig_next) : '0;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_finish)
                begin
                    if (job_reg.negative)
                        state_next = ST_SIGN;
                    else if (job_reg.has_prefix)
                        state_next = ST_PRE0;
                    else if (pad_calc != '0)
                        state_next = ST_PAD;
                    else
                        state_next = ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (load)
                begin
                    if (job_reg.has_prefix)
                        state_next = ST_PRE0;
                    else if (pad_reg != '0)
                        state_next = ST_PAD;
                    else
                        state_next = ST_DIGIT;
                end
            end
            ST_PRE0:
            begin
                if (load)
                    state_next = ST_PRE1;
            end
            ST_PRE1:
            begin
                if (load)
                    state_next = (pad_reg != '0) ? ST_PAD : ST_DIGIT;
            end
            ST_PAD:
            begin
                if (load && (pad_reg == CNT_W'(1)))
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (load && (idx_reg == '0))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs of each state
    always_comb
    begin
        pop       = 1'b0;
        emit      = 1'b0;
        emit_ch   = CH_ZERO;
        emit_last = 1'b0;
        unique case (state_reg)
            ST_IDLE:  pop = !empty;
            ST_DIV:   emit = 1'b0;
            ST_SIGN:  begin emit = 1'b1; emit_ch = CH_MINUS; end
            ST_PRE0:  begin emit = 1'b1; emit_ch = CH_ZERO; end
            ST_PRE1:  begin emit = 1'b1; emit_ch = job_reg.prefix_ch; end
            ST_PAD:   begin emit = 1'b1; emit_ch = CH_ZERO; end
            ST_DIGIT:
            begin
                emit      = 1'b1;
                emit_ch   = digit_char(dig_reg[idx_reg]);
                emit_last = (idx_reg == '0);
            end
            default:  emit = 1'b0;
        endcase
    end

    // Load the output register when it is empty or being drained
    assign load      = emit && (!out_valid_reg || txt_ready);
    assign txt_valid = out_valid_reg;
    assign txt_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (txt_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath: load the output beat, take a job, run the digit loop, count out pad and digits
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.char_out <= emit_ch;
            out_reg.last     <= emit_last;
        end
        if (pop)
        begin
            job_reg  <= pop_job;
            work_reg <= pop_job.mag;
            quot_reg <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
            ndig_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            if (digit_done)
            begin
                dig_reg[ndig_reg[DIG_IDX_W-1:0]] <= digit_val;
                ndig_reg <= ndig_next;
                work_reg <= rest;
                quot_reg <= '0;
                rem_reg  <= '0;
                step_reg <= '0;
                if (div_finish)
                begin
                    pad_reg <= pad_calc;
                    idx_reg <= ndig_reg[DIG_IDX_W-1:0];
                end
            end
            else
            begin
                work_reg <= div_work;
                quot_reg <= div_quot;
                rem_reg  <= div_rem;
                step_reg <= step_reg + 1'b1;
            end
        end
        else if (load && (state_reg == ST_PAD))
        begin
            pad_reg <= pad_reg - 1'b1;
        end
        else if (load && (state_reg == ST_DIGIT))
        begin
            idx_reg <= idx_reg - 1'b1;
        end
    end

endmodule

FILE: verif/testbench.sv
module testbench;

    import itoa_pkg::*;

    localparam int PAD_CAP     = PAD_LIMIT_DEF;
    localparam int TAIL_CYCLES = 400;
    localparam int LIMIT_TIME  = 100_000_000;

    // Digit glyphs, index 0 in the top byte
    localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789ABCDEF";

    logic      clk;
    logic      rst_n;
    logic      num_valid;
    logic      num_ready;
    itoa_num_t num_data;
    logic      txt_valid;
    logic      txt_ready;
    itoa_txt_t txt_data;

    // Characters still owed by the block, oldest first
    itoa_txt_t expected_text[$];
    itoa_txt_t oldest_char;
    int        error_count = 0;
    bit        tx_steady   = 1'b0;
    bit        rx_steady   = 1'b0;

    integer_to_ascii_radix_formatter #(
        .PAD_LIMIT(PAD_CAP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .num_valid(num_valid),
        .num_ready(num_ready),
        .num_data (num_data),
        .txt_valid(txt_valid),
        .txt_ready(txt_ready),
        .txt_data (txt_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic itoa_num_t make_item(input logic [DATA_WIDTH-1:0] value,
                                            input logic [BASE_IN_W-1:0]  radix,
                                            input logic                  prefix,
                                            input logic [MIN_DIG_W-1:0]  min_len);
        itoa_num_t item;
        item.number      = value;
        item.base        = radix;
        item.with_prefix = prefix;
        item.min_digits  = min_len;
        return item;
    endfunction

    // Format one number into the characters the block must emit
    function automatic void predict_text(input itoa_num_t item);
        logic [DATA_WIDTH-1:0] magnitude;
        logic [DATA_WIDTH-1:0] radix;
        logic [3:0]            digit_val[$];
        logic [CHAR_W-1:0]     glyphs[$];
        logic [CHAR_W-1:0]     prefix_ch;
        int unsigned           pad_to;
        itoa_txt_t             beat;
        if (item.base < BASE_MIN || item.base > BASE_MAX)
            return;
        magnitude = item.number;
        if (item.number[DATA_WIDTH-1])
            magnitude = ~magnitude + 1'b1;
        radix = {{(DATA_WIDTH-BASE_IN_W){1'b0}}, item.base};

        // Collect digits, most significant ends up first
        do
        begin
            digit_val.push_front(4'(magnitude % radix));
            magnitude = magnitude / radix;
        end
        while (magnitude != 0);

        pad_to = (item.min_digits > PAD_CAP) ? PAD_CAP : item.min_digits;
        case (item.base)
            BASE_BIN: prefix_ch = CH_B;
            BASE_OCT: prefix_ch = CH_O;
            BASE_DEC: prefix_ch = CH_D;
            BASE_HEX: prefix_ch = CH_X;
            default:  prefix_ch = '0;
        endcase

        // Sign, prefix, padding, digits
        if (item.number[DATA_WIDTH-1])
            glyphs.push_back(CH_MINUS);
        if (item.with_prefix && prefix_ch != '0)
        begin
            glyphs.push_back(CH_ZERO);
            glyphs.push_back(prefix_ch);
        end
        for (int i = digit_val.size(); i < int'(pad_to); i++)
            glyphs.push_back(CH_ZERO);
        foreach (digit_val[k])
            glyphs.push_back(DIGIT_GLYPHS[8*(15 - int'(digit_val[k])) +: CHAR_W]);

        foreach (glyphs[k])
        begin
            beat.char_out = glyphs[k];
            beat.last     = (k == glyphs.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    // Offer one number, hold it until taken, then queue its text
    task automatic send_number(input itoa_num_t item);
        int unsigned gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            num_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        num_data  <= item;
        num_valid <= 1'b1;
        do @(posedge clk); while (!num_ready);
        predict_text(item);
    endtask

    // Drop the input and wait for every owed character
    task automatic wait_text_done();
        num_valid <= 1'b0;
        @(posedge clk);
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    // Zero, both ends of the range, longest possible text
    task automatic test_extremes();
        send_number(make_item(32'd0,          BASE_DEC, 1'b0, 8'd0));
        send_number(make_item(32'd0,          BASE_BIN, 1'b1, 8'd0));
        send_number(make_item(32'h8000_0000,  BASE_DEC, 1'b1, 8'd0));
        send_number(make_item(32'h8000_0000,  BASE_BIN, 1'b1, 8'd255));
        send_number(make_item(32'h7FFF_FFFF,  BASE_BIN, 1'b0, 8'd0));
        send_number(make_item(32'h7FFF_FFFF,  BASE_DEC, 1'b1, 8'd1));
        send_number(make_item(32'hFFFF_FFFF,  BASE_HEX, 1'b0, 8'd0));
    endtask

    // Every prefix, and prefix requests that must be ignored
    task automatic test_prefixes();
        send_number(make_item(32'd5,          BASE_BIN, 1'b1, 8'd4));
        send_number(make_item(32'o1234567,    BASE_OCT, 1'b1, 8'd0));
        send_number(make_item(-32'sd90210,    BASE_DEC, 1'b1, 8'd0));
        send_number(make_item(32'h00AB_CDEF,  BASE_HEX, 1'b1, 8'd0));
        send_number(make_item(32'd100,        8'd3,     1'b1, 8'd0));
        send_number(make_item(32'd255,        BASE_QUA, 1'b1, 8'd0));
        send_number(make_item(32'd987654,     8'd15,    1'b1, 8'd2));
    endtask

    // Padding below, at and above the cap
    task automatic test_padding();
        send_number(make_item(32'd42,         BASE_DEC, 1'b0, 8'd5));
        send_number(make_item(32'd7,          BASE_OCT, 1'b1, 8'(PAD_CAP)));
        send_number(make_item(-32'sd3,        BASE_HEX, 1'b1, 8'(PAD_CAP + 1)));
        send_number(make_item(32'd0,          8'd7,     1'b0, 8'd255));
    endtask

    // Bases outside 2..16 give nothing
    task automatic test_bad_bases();
        send_number(make_item(32'd12,         8'd0,     1'b1, 8'd3));
        send_number(make_item(32'd12,         8'd1,     1'b0, 8'd0));
        send_number(make_item(32'h8000_0000,  8'd17,    1'b1, 8'd255));
        send_number(make_item(32'hFFFF_FFFF,  8'd255,   1'b1, 8'd170));
        send_number(make_item(32'd1,          8'd128,   1'b0, 8'd85));
    endtask

    // Random numbers, bases and padding with a little noise mixed in
    task automatic test_random_items(input int unsigned wanted);
        itoa_num_t   item;
        int unsigned sent;
        bit          noise;
        sent = 0;
        while (sent < wanted)
        begin
            // Change the idling mode now and then
            if ($urandom_range(0, 29) == 0)
            begin
                tx_steady = ($urandom_range(0, 2) == 0);
                rx_steady = ($urandom_range(0, 2) == 0);
            end

            case ($urandom_range(0, 5))
                0, 1: item.number = $urandom;
                2:    item.number = $urandom_range(0, 300);
                3:    item.number = 0 - $urandom_range(1, 1000);
                4:    item.number = ($urandom_range(0, 1) == 1) ?
                                    32'h8000_0000 + $urandom_range(0, 3) :
                                    32'h7FFF_FFFF - $urandom_range(0, 3);
                default: item.number = 32'd1 << $urandom_range(0, 31);
            endcase

            noise = ($urandom_range(0, 99) < 12);
            if (noise)
                item.base = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1)) :
                                                          8'($urandom_range(17, 255));
            else if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 3))
                    0:       item.base = BASE_BIN;
                    1:       item.base = BASE_OCT;
                    2:       item.base = BASE_DEC;
                    default: item.base = BASE_HEX;
                endcase
            end
            else
                item.base = 8'($urandom_range(2, 16));

            item.with_prefix = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0:       item.min_digits = 8'($urandom_range(0, 255));
                1, 2:    item.min_digits = 8'($urandom_range(13, 40));
                default: item.min_digits = 8'($urandom_range(0, 12));
            endcase

            send_number(item);
            if (!noise)
                sent++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Let the block run dry between bursts of long texts
    task automatic test_pause_until_idle();
        repeat (3)
            send_number(make_item(32'h8000_0000, BASE_BIN, 1'b1, 8'd0));
        wait_text_done();
        send_number(make_item(32'h8000_0000, BASE_DEC, 1'b1, 8'd12));
        send_number(make_item(32'd31, BASE_HEX, 1'b1, 8'd31));
    endtask

    // Reset, run the tests, report
    initial
    begin
        rst_n      = 1'b0;
        num_valid <= 1'b0;
        num_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_prefixes();
        test_padding();
        test_bad_bases();
        test_random_items(100);
        test_pause_until_idle();
        test_random_items(100);

        wait_text_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Output stalls: alternate ready runs and stall gaps
    initial
    begin
        txt_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int unsigned stall;
            stall = rx_steady ? 0 : pick_gap();
            if (stall != 0)
            begin
                txt_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            txt_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Check each output beat against the oldest owed character
    always @(posedge clk)
    begin
        if (rst_n && txt_valid && txt_ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected beat: char_out %h last %b",
                       txt_data.char_out, txt_data.last);
                error_count++;
            end
            else
            begin
                oldest_char = expected_text.pop_front();
                if (txt_data.char_out !== oldest_char.char_out)
                begin
                    $error("char_out: expected %h got %h",
                           oldest_char.char_out, txt_data.char_out);
                    error_count++;
                end
                if (txt_data.last !== oldest_char.last)
                begin
                    $error("last: expected %b got %b", oldest_char.last, txt_data.last);
                    error_count++;
                end
            end
        end
    end

    // Give up after a generous fixed time
    initial
    begin
        #(LIMIT_TIME);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
